// ===== rtl/dfrv_pkg.sv =====
package dfrv_pkg;

  localparam int NUM_REGIONS_DEF = 6;
  localparam int NUM_DIGITS_DEF  = 7;
  localparam int MAX_FRAME_DEF   = 36;
  localparam int SUM_BITS_DEF    = 16;

  localparam int WINDOW_COUNT = 6;

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h6B;

  // Item kinds carried in tuser.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes; windows take indexes 0 to WINDOW_COUNT-1.
  localparam logic [2:0] REG_ENABLE = 3'd6;
  localparam logic [2:0] REG_ROUNDS = 3'd7;

  localparam logic [31:0] WINDOW_RESET [WINDOW_COUNT] = '{
    32'd1515895090, 32'd1515852395, 32'd1515853779,
    32'd1515894817, 32'd1515866408, 32'd1515856323
  };
  localparam logic [5:0] ENABLE_RESET = 6'd0;
  localparam logic [7:0] ROUNDS_RESET = 8'd1;

  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOTE_RD,
    ST_VOTE_WR,
    ST_DEC_RD,
    ST_DEC_CMP,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dfrv_ram.sv =====
module dfrv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 42
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/detection_frame_region_vote.sv =====
// Sequencing: an item that does not complete a frame is accepted in ST_IDLE and then
// offers its result beat on the next cycle. A completed frame adds a ST_VOTE_RD step per
// region plus a ST_VOTE_WR step per region hit (read, then saturating add through the sum
// memory port), and a round end adds a ST_DEC_RD step per disabled region plus a read and a
// compare step per digit of each enabled region, all on the single compare unit. One item
// is in flight at a time; s_tready is low until its result beat is taken. Reset is
// synchronous: framing, counts, decided digits and all sums read as zero.
module detection_frame_region_vote #(
  parameter int NUM_REGIONS = dfrv_pkg::NUM_REGIONS_DEF,
  parameter int NUM_DIGITS  = dfrv_pkg::NUM_DIGITS_DEF,
  parameter int MAX_FRAME   = dfrv_pkg::MAX_FRAME_DEF,
  parameter int SUM_BITS    = dfrv_pkg::SUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // frame_taken, round_done, digit_region0 .. digit_region5
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import dfrv_pkg::*;

  localparam int DEPTH  = NUM_REGIONS * NUM_DIGITS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RIDX_W = NUM_REGIONS > 1 ? $clog2(NUM_REGIONS) : 1;
  localparam int DIG_W  = $clog2(NUM_DIGITS);
  localparam int FLEN_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W1 = SUM_BITS + 1;

  state_t state, state_next;

  logic [31:0]         window [NUM_REGIONS];
  logic [5:0]          enable_mask;
  logic [7:0]          round_packets;

  logic                in_frame;
  logic [FLEN_W-1:0]   frame_length;
  logic [7:0]          field_bytes [4];
  logic [7:0]          frames_in_round;
  logic                round_finished;
  logic [DIG_W-1:0]    region_digits [NUM_REGIONS];
  logic                frame_taken;
  logic                decide;
  logic [DEPTH-1:0]    sum_valid;

  logic [RIDX_W-1:0]   region_idx;
  logic [DIG_W-1:0]    digit_idx;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   addr_q;
  logic [SUM_BITS-1:0] best;
  logic [DIG_W-1:0]    best_idx;
  logic                rvalid;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SUM_BITS-1:0] ram_rdata;
  logic [SUM_BITS-1:0] rd_val;
  logic [SUM_W1-1:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_sat;

  logic [31:0]         win;
  logic [8:0]          px, py, cx, cy, hw, hh;
  logic                in_window, digit_ok, region_en, hit;
  logic                last_region, last_digit;
  logic [ADDR_W-1:0]   vote_addr, dec_addr;

  logic [7:0]          fir_inc;
  logic                round_end;
  logic                stored;
  logic                take_frame;
  logic [FLEN_W-1:0]   fl_off;

  // Window test for the region under the sequencer; bounds are kept in 9 bits so that
  // nothing wraps at either end of the byte range.
  always_comb begin
    win       = window[region_idx];
    px        = {1'b0, field_bytes[1]};
    py        = {1'b0, field_bytes[2]};
    cx        = {1'b0, win[7:0]};
    cy        = {1'b0, win[15:8]};
    hw        = {2'b00, win[23:17]};
    hh        = {2'b00, win[31:25]};
    in_window = (px + hw >= cx) && (px <= cx + hw) && (py + hh >= cy) && (py <= cy + hh);
    digit_ok  = field_bytes[0] < 8'(NUM_DIGITS);
    region_en = enable_mask[region_idx];
    hit       = region_en && in_window && digit_ok;
    last_region = region_idx == RIDX_W'(NUM_REGIONS - 1);
    last_digit  = digit_idx == DIG_W'(NUM_DIGITS - 1);
    vote_addr = base + ADDR_W'(field_bytes[0][DIG_W-1:0]);
    dec_addr  = base + ADDR_W'(digit_idx);
    rd_val    = rvalid ? ram_rdata : '0;
    sum_wide  = {1'b0, rd_val} + SUM_W1'(field_bytes[3]);
    sum_sat   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    fir_inc   = frames_in_round + 8'd1;
    round_end = fir_inc >= round_packets;
    stored    = frame_length < FLEN_W'(MAX_FRAME);
    take_frame = s_tuser == KIND_BYTE && !round_finished && in_frame &&
                 s_tdata == TAIL_BYTE && stored;
    fl_off    = frame_length - FLEN_W'(2);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (take_frame) begin
            state_next = ST_VOTE_RD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_VOTE_RD: begin
        if (hit) begin
          state_next = ST_VOTE_WR;
        end else if (last_region) begin
          state_next = decide ? ST_DEC_RD : ST_OUT;
        end
      end
      ST_VOTE_WR: begin
        if (last_region) begin
          state_next = decide ? ST_DEC_RD : ST_OUT;
        end else begin
          state_next = ST_VOTE_RD;
        end
      end
      ST_DEC_RD: begin
        if (region_en) begin
          state_next = ST_DEC_CMP;
        end else if (last_region) begin
          state_next = ST_OUT;
        end
      end
      ST_DEC_CMP: begin
        if (last_digit && last_region) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_DEC_RD;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = state == ST_IDLE;
    m_tvalid  = state == ST_OUT;
    cfg_ready = 1'b1;
    ram_we    = state == ST_VOTE_WR;
    ram_raddr = (state == ST_DEC_RD) ? dec_addr : vote_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      for (int i = 0; i < NUM_REGIONS; i++) begin
        window[i] <= WINDOW_RESET[i];
      end
      enable_mask     <= ENABLE_RESET;
      round_packets   <= ROUNDS_RESET;
      in_frame        <= 1'b0;
      frame_length    <= '0;
      field_bytes     <= '{default: '0};
      frames_in_round <= '0;
      round_finished  <= 1'b0;
      region_digits   <= '{default: '0};
      frame_taken     <= 1'b0;
      decide          <= 1'b0;
      sum_valid       <= '0;
      region_idx      <= '0;
      digit_idx       <= '0;
      base            <= '0;
      best            <= '0;
      best_idx        <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE: enable_mask   <= cfg_data[5:0];
          REG_ROUNDS: round_packets <= cfg_data[7:0];
          default: begin
            if (int'(cfg_index) < NUM_REGIONS) begin
              window[cfg_index[RIDX_W-1:0]] <= cfg_data;
            end
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          region_idx <= '0;
          digit_idx  <= '0;
          base       <= '0;
          best       <= '0;
          best_idx   <= '0;
          if (s_tvalid) begin
            frame_taken <= take_frame;
            case (s_tuser)
              KIND_START: round_finished <= 1'b0;
              KIND_CLEAR: begin
                sum_valid     <= '0;
                region_digits <= '{default: '0};
              end
              KIND_BYTE: begin
                if (!round_finished) begin
                  if (!in_frame) begin
                    if (s_tdata == HEAD_BYTE) begin
                      in_frame     <= 1'b1;
                      frame_length <= FLEN_W'(2);
                    end
                  end else begin
                    if (stored) begin
                      if (frame_length >= FLEN_W'(2) && frame_length < FLEN_W'(6)) begin
                        field_bytes[fl_off[1:0]] <= s_tdata;
                      end
                    end
                    if (s_tdata == TAIL_BYTE) begin
                      in_frame     <= 1'b0;
                      frame_length <= '0;
                      if (stored) begin
                        decide          <= round_end;
                        frames_in_round <= round_end ? 8'd0 : fir_inc;
                      end
                    end else if (stored) begin
                      frame_length <= frame_length + FLEN_W'(1);
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_VOTE_RD: begin
          addr_q <= vote_addr;
          if (!hit) begin
            region_idx <= last_region ? '0 : region_idx + RIDX_W'(1);
            base       <= last_region ? '0 : base + ADDR_W'(NUM_DIGITS);
          end
        end
        ST_VOTE_WR: begin
          sum_valid[addr_q] <= 1'b1;
          region_idx <= last_region ? '0 : region_idx + RIDX_W'(1);
          base       <= last_region ? '0 : base + ADDR_W'(NUM_DIGITS);
        end
        ST_DEC_RD: begin
          if (!region_en) begin
            region_idx <= region_idx + RIDX_W'(1);
            base       <= base + ADDR_W'(NUM_DIGITS);
            if (last_region) begin
              round_finished <= 1'b1;
            end
          end
        end
        ST_DEC_CMP: begin
          // Strict compare keeps the first digit that reaches the maximum.
          if (last_digit) begin
            region_digits[region_idx] <= (rd_val > best) ? digit_idx : best_idx;
            best       <= '0;
            best_idx   <= '0;
            digit_idx  <= '0;
            region_idx <= region_idx + RIDX_W'(1);
            base       <= base + ADDR_W'(NUM_DIGITS);
            if (last_region) begin
              round_finished <= 1'b1;
            end
          end else begin
            if (rd_val > best) begin
              best     <= rd_val;
              best_idx <= digit_idx;
            end
            digit_idx <= digit_idx + DIG_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // A sum entry that has not been written since reset or a clear reads as zero.
  always_ff @(posedge clk) begin
    rvalid <= sum_valid[ram_raddr];
  end

  dfrv_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (sum_sat),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata[0]     = frame_taken;
  assign m_tdata[1]     = round_finished;
  assign m_tdata[23:20] = 4'b0000;

  for (genvar r = 0; r < WINDOW_COUNT; r++) begin : g_digit_out
    if (r < NUM_REGIONS) begin : g_used
      logic [DIG_W+2:0] digit_ext;
      assign digit_ext = {3'b000, region_digits[r]};
      assign m_tdata[2 + 3 * r +: 3] = digit_ext[2:0];
    end else begin : g_unused
      assign m_tdata[2 + 3 * r +: 3] = 3'b000;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dfrv_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SUM_LIMIT = (1 << SUM_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 50;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [2:0]  idx;
    logic [1:0]  kind;
    logic [31:0] val;
    logic [7:0]  reps;
    logic        chk;
    logic [23:0] res;
  } row_t;

  localparam int DIR_ROWS = 34;

  // Directed opening. Rows with chk set carry a result that is plain from the spec;
  // the others are checked against the vote predictor.
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h00,        8'd1,  1'b1, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_UNUSED, 32'hFF,        8'd1,  1'b1, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b1, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b1, 24'h000003},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b1, 24'h000002},
    '{ROW_ITEM, 3'd0, KIND_START,  32'hFF,        8'd1,  1'b1, 24'h000000},
    '{ROW_CFG,  3'd0, KIND_BYTE,   32'hFFFF_8080, 8'd1,  1'b0, 24'h000000},
    '{ROW_CFG,  3'd1, KIND_BYTE,   32'h0000_0000, 8'd1,  1'b0, 24'h000000},
    '{ROW_CFG,  REG_ENABLE, KIND_BYTE, 32'h3F,    8'd1,  1'b0, 24'h000000},
    '{ROW_CFG,  REG_ROUNDS, KIND_BYTE, 32'h02,    8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h03,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h80,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h80,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hFF,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_START,  32'h00,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h07,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h00,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h00,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hFF,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_START,  32'h55,        8'd1,  1'b0, 24'h000000},
    '{ROW_CFG,  REG_ROUNDS, KIND_BYTE, 32'h00,    8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h00,        8'd40, 1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'hAA,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h01,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_CLEAR,  32'hAA,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_START,  32'h00,        8'd1,  1'b0, 24'h000000},
    '{ROW_ITEM, 3'd0, KIND_BYTE,   32'h6B,        8'd1,  1'b0, 24'h000000}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = KIND_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  // Predictor copy of the registers and the voting state.
  logic [31:0] pr_window [WINDOW_COUNT];
  logic [5:0]  pr_enable;
  logic [7:0]  pr_rounds;
  logic        pr_in_frame;
  int          pr_len;
  logic [7:0]  pr_field [4];
  int unsigned pr_sum [NUM_REGIONS_DEF][NUM_DIGITS_DEF];
  logic [7:0]  pr_frames;
  logic        pr_done;
  logic [2:0]  pr_digit [NUM_REGIONS_DEF];

  logic [23:0] vote_expected [$];
  logic [23:0] oldest_vote;
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          frames_taken = 0;
  int          rounds_decided = 0;
  int          settings_written = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;

  always #5 clk = ~clk;

  detection_frame_region_vote DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [23:0] vote_predict(input logic [1:0] kind, input logic [7:0] b);
    logic        taken;
    logic        stored;
    logic [23:0] res;
    int          px, py, cx, cy, hw, hh, dg;
    int unsigned s, best, idx;
    taken = 1'b0;
    if (kind == KIND_START) begin
      pr_done = 1'b0;
    end else if (kind == KIND_CLEAR) begin
      for (int r = 0; r < NUM_REGIONS_DEF; r++) begin
        pr_digit[r] = 3'd0;
        for (int j = 0; j < NUM_DIGITS_DEF; j++) pr_sum[r][j] = 0;
      end
    end else if (kind == KIND_BYTE && !pr_done) begin
      if (!pr_in_frame) begin
        if (b == HEAD_BYTE) begin
          pr_in_frame = 1'b1;
          pr_len = 2;
        end
      end else begin
        stored = 1'b0;
        if (pr_len < MAX_FRAME_DEF) begin
          if (pr_len >= 2 && pr_len < 6) pr_field[pr_len - 2] = b;
          pr_len++;
          stored = 1'b1;
        end
        if (b == TAIL_BYTE) begin
          if (stored) begin
            taken = 1'b1;
            frames_taken++;
            dg = pr_field[0];
            px = pr_field[1];
            py = pr_field[2];
            pr_frames = pr_frames + 8'd1;
            for (int r = 0; r < NUM_REGIONS_DEF; r++) begin
              cx = pr_window[r][7:0];
              cy = pr_window[r][15:8];
              hw = pr_window[r][23:16] / 2;
              hh = pr_window[r][31:24] / 2;
              if (pr_enable[r] && px >= cx - hw && px <= cx + hw && py >= cy - hh &&
                  py <= cy + hh && dg < NUM_DIGITS_DEF) begin
                s = pr_sum[r][dg] + pr_field[3];
                pr_sum[r][dg] = (s > SUM_LIMIT) ? SUM_LIMIT : s;
              end
            end
            if (pr_frames >= pr_rounds) begin
              pr_frames = 8'd0;
              rounds_decided++;
              for (int r = 0; r < NUM_REGIONS_DEF; r++) begin
                if (pr_enable[r]) begin
                  best = 0;
                  idx = 0;
                  for (int j = 0; j < NUM_DIGITS_DEF; j++) begin
                    if (pr_sum[r][j] > best) begin
                      best = pr_sum[r][j];
                      idx = j;
                    end
                  end
                  pr_digit[r] = 3'(idx);
                end
              end
              pr_done = 1'b1;
            end
          end
          pr_in_frame = 1'b0;
          pr_len = 0;
        end
      end
    end
    res = '0;
    res[0] = taken;
    res[1] = pr_done;
    for (int r = 0; r < NUM_REGIONS_DEF; r++) res[2 + 3 * r +: 3] = pr_digit[r];
    return res;
  endfunction

  function automatic logic [3:0] field_of(input logic [23:0] v, input int f);
    if (f == 0) return {3'd0, v[0]};
    if (f == 1) return {3'd0, v[1]};
    if (f < 8) return {1'b0, v[3 * f - 4 +: 3]};
    return v[23:20];
  endfunction

  function automatic logic [7:0] near_coord(input int c, input int half);
    int v;
    v = c - half - 1 + int'($urandom_range(0, 2 * half + 2));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == TAIL_BYTE);
    return b;
  endfunction

  task automatic item_send(input logic [1:0] kind, input logic [7:0] b,
                           input logic chk, input logic [23:0] lit);
    int gap;
    logic [23:0] pv;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (s_tvalid) s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    beats_in++;
    pv = vote_predict(kind, b);
    vote_expected.push_back(chk ? lit : pv);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    if (s_tvalid) s_tvalid <= 1'b0;
    burst_left = 0;
    while (vote_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
    if (idx < WINDOW_COUNT) pr_window[idx] = val;
    else if (idx == REG_ENABLE) pr_enable = val[5:0];
    else if (idx == REG_ROUNDS) pr_rounds = val[7:0];
  endtask

  // Result beats are checked here; m_tready follows a stall pattern that changes mode
  // whenever the stall_left countdown runs out.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (vote_expected.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, actual %06h", $time, m_tdata);
      end else begin
        oldest_vote = vote_expected.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (field_of(oldest_vote, f) !== field_of(m_tdata, f)) begin
            mismatches++;
            $display("%0t: result field %0d expected %0h actual %0h", $time, f,
                     field_of(oldest_vote, f), field_of(m_tdata, f));
          end
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    #20_000_000;
    $display("detection_frame_region_vote: mismatch");
    $finish;
  end

  initial begin
    int          pick, rg, cx, cy, hw, hh, start_beats;
    logic [31:0] w;
    logic [5:0]  en;
    logic [7:0]  rounds, digit, x, y, sc;

    for (int r = 0; r < WINDOW_COUNT; r++) pr_window[r] = WINDOW_RESET[r];
    pr_enable = ENABLE_RESET;
    pr_rounds = ROUNDS_RESET;
    pr_in_frame = 1'b0;
    pr_len = 0;
    for (int i = 0; i < 4; i++) pr_field[i] = 8'd0;
    for (int r = 0; r < NUM_REGIONS_DEF; r++) begin
      pr_digit[r] = 3'd0;
      for (int j = 0; j < NUM_DIGITS_DEF; j++) pr_sum[r][j] = 0;
    end
    pr_frames = 8'd0;
    pr_done = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].op == ROW_CFG) begin
        reg_write(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        for (int n = 0; n < DIRECTED[i].reps; n++)
          item_send(DIRECTED[i].kind, DIRECTED[i].val[7:0], DIRECTED[i].chk, DIRECTED[i].res);
      end
    end

    // Saturation run: every region covers almost the whole image, so digit 0 of each
    // region gains the full score on every frame. After one full frame the rest are
    // short frames that keep the stale y and score. A round of 255 frames ends first,
    // then a few short rounds push the sums into saturation.
    item_send(KIND_CLEAR, 8'h00, 1'b0, 24'h0);
    for (int r = 0; r < WINDOW_COUNT; r++) reg_write(3'(r), 32'hFFFF_7F7F);
    reg_write(REG_ENABLE, 32'h3F);
    reg_write(REG_ROUNDS, 32'd255);
    item_send(KIND_START, 8'h00, 1'b0, 24'h0);
    for (int f = 0; f < 268; f++) begin
      if (f == 255) reg_write(REG_ROUNDS, 32'd3);
      if (f >= 255) item_send(KIND_START, 8'($urandom), 1'b0, 24'h0);
      item_send(KIND_BYTE, HEAD_BYTE, 1'b0, 24'h0);
      item_send(KIND_BYTE, 8'd0, 1'b0, 24'h0);
      if (f == 0) begin
        item_send(KIND_BYTE, 8'($urandom_range(0, 254)), 1'b0, 24'h0);
        item_send(KIND_BYTE, 8'($urandom_range(0, 254)), 1'b0, 24'h0);
        item_send(KIND_BYTE, 8'hFF, 1'b0, 24'h0);
      end
      item_send(KIND_BYTE, TAIL_BYTE, 1'b0, 24'h0);
    end

    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < WINDOW_COUNT; r++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) w = 32'h0000_0000;
        else if (pick == 1) w = 32'hFFFF_FFFF;
        else w = $urandom;
        reg_write(3'(r), w);
      end
      case (ph)
        0: begin en = 6'h3F; rounds = 8'd1; end
        1: begin en = 6'($urandom); rounds = 8'd2; end
        2: begin en = 6'h00; rounds = 8'd0; end
        3: begin en = 6'($urandom); rounds = 8'($urandom_range(0, 5)); end
        default: begin en = 6'h3F; rounds = 8'd0; end
      endcase
      reg_write(REG_ENABLE, {26'd0, en});
      reg_write(REG_ROUNDS, {24'd0, rounds});
      start_beats = beats_in;
      while (beats_in - start_beats < 190) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          rg = $urandom_range(0, WINDOW_COUNT - 1);
          cx = pr_window[rg][7:0];
          cy = pr_window[rg][15:8];
          hw = pr_window[rg][23:16] / 2;
          hh = pr_window[rg][31:24] / 2;
          digit = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(7, 255)) :
                                                8'($urandom_range(0, 6));
          if ($urandom_range(0, 9) < 7) begin
            x = near_coord(cx, hw);
            y = near_coord(cy, hh);
          end else begin
            x = 8'($urandom);
            y = 8'($urandom);
          end
          case ($urandom_range(0, 9))
            0: sc = 8'hFF;
            1: sc = 8'h00;
            default: sc = 8'($urandom);
          endcase
          item_send(KIND_BYTE, HEAD_BYTE, 1'b0, 24'h0);
          item_send(KIND_BYTE, digit, 1'b0, 24'h0);
          item_send(KIND_BYTE, x, 1'b0, 24'h0);
          item_send(KIND_BYTE, y, 1'b0, 24'h0);
          item_send(KIND_BYTE, sc, 1'b0, 24'h0);
          if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) item_send(KIND_BYTE, body_byte(), 1'b0, 24'h0);
          item_send(KIND_BYTE, TAIL_BYTE, 1'b0, 24'h0);
          if ($urandom_range(0, 1) == 0) item_send(KIND_START, 8'($urandom), 1'b0, 24'h0);
        end else if (pick < 70) begin
          // Short frame: the missing field positions keep their old contents.
          item_send(KIND_BYTE, HEAD_BYTE, 1'b0, 24'h0);
          repeat ($urandom_range(0, 3)) item_send(KIND_BYTE, body_byte(), 1'b0, 24'h0);
          item_send(KIND_BYTE, TAIL_BYTE, 1'b0, 24'h0);
        end else if (pick < 73) begin
          // Long frame whose tail lands on either side of the length limit.
          item_send(KIND_BYTE, HEAD_BYTE, 1'b0, 24'h0);
          repeat ($urandom_range(32, 36)) item_send(KIND_BYTE, body_byte(), 1'b0, 24'h0);
          item_send(KIND_BYTE, TAIL_BYTE, 1'b0, 24'h0);
        end else if (pick < 83) begin
          repeat ($urandom_range(1, 4)) item_send(KIND_BYTE, 8'($urandom), 1'b0, 24'h0);
        end else if (pick < 95) begin
          item_send(KIND_START, 8'($urandom), 1'b0, 24'h0);
        end else if (pick < 97) begin
          item_send(KIND_CLEAR, 8'($urandom), 1'b0, 24'h0);
        end else begin
          item_send(KIND_UNUSED, 8'($urandom), 1'b0, 24'h0);
        end
      end
    end

    if (s_tvalid) s_tvalid <= 1'b0;
    while (vote_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats and checked %0d result beats over %0d register writes.",
             beats_in, beats_out, settings_written);
    $display("Frames accepted: %0d, voting rounds decided: %0d.", frames_taken, rounds_decided);
    if (mismatches == 0) begin
      $display("detection_frame_region_vote: match");
    end else begin
      $display("detection_frame_region_vote: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dfrv_pkg.sv
rtl/dfrv_ram.sv
rtl/detection_frame_region_vote.sv
dv/tb_top.sv
